### hw/rtl/pgmap_pkg.sv
`default_nettype none

package pgmap_pkg;

    localparam int VA_W         = 48;
    localparam int FRAME_W      = 40;
    localparam int ENTRY_W      = 52;
    localparam int IDX_W        = 9;
    localparam int PAGE_SHIFT   = 12;
    localparam int LEVELS       = 4;
    localparam int ENT_PRESENT  = 0;
    localparam int ENT_WRITABLE = 1;

    localparam int POOL_PAGES_DEF = 16;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_OUTSIDE   = 2'd2
    } status_t;

    typedef struct packed {
        logic [VA_W-1:0]    virtual_address;
        logic [FRAME_W-1:0] physical_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         tables_taken;
        logic [ENTRY_W-1:0] leaf_entry;
    } out_item_t;

    // Present, writable entry pointing at the given frame.
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame);
        logic [ENTRY_W-1:0] e;
        e = '0;
        e[ENTRY_W-1:PAGE_SHIFT] = frame;
        e[ENT_PRESENT] = 1'b1;
        e[ENT_WRITABLE] = 1'b1;
        return e;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pgmap_ram.sv
`default_nettype none

module pgmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/pgmap_outbuf.sv
`default_nettype none

module pgmap_outbuf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    output logic                      res_ready,
    input  wire pgmap_pkg::out_item_t res_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output pgmap_pkg::out_item_t      out_data
);

    logic                 valid_reg;
    logic                 valid_next;
    pgmap_pkg::out_item_t data_reg;
    pgmap_pkg::out_item_t data_next;

    // The slot can take a new beat when it is empty or is being emptied now.
    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### hw/rtl/pgmap_walker.sv
`default_nettype none

module pgmap_walker #(
    parameter int POOL_PAGES = pgmap_pkg::POOL_PAGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [pgmap_pkg::FRAME_W-1:0] pool_base,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pgmap_pkg::in_item_t           in_data,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output pgmap_pkg::out_item_t               res_data
);

    localparam int FW     = pgmap_pkg::FRAME_W;
    localparam int EW     = pgmap_pkg::ENTRY_W;
    localparam int IW     = pgmap_pkg::IDX_W;
    localparam int PS     = pgmap_pkg::PAGE_SHIFT;
    localparam int NL     = pgmap_pkg::LEVELS;
    localparam int PW     = $clog2(POOL_PAGES);
    localparam int UW     = $clog2(POOL_PAGES + 1);
    localparam int DEPTH  = POOL_PAGES * (2 ** IW);
    localparam int AW     = $clog2(DEPTH);
    localparam int MW     = EW + 1;
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [FW-1:0] POOL_LIMIT = FW'(POOL_PAGES);
    localparam logic [UW:0]   POOL_CAP   = (UW + 1)'(POOL_PAGES);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_EVAL  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_ALLOC = 9'b000100000,
        S_LINK  = 9'b001000000,
        S_LEAF  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [IW-1:0]        idx_reg [NL];
    logic [IW-1:0]        idx_next [NL];
    logic [PW-1:0]        page_reg [NL];
    logic [PW-1:0]        page_next [NL];
    logic [FW-1:0]        frame_reg, frame_next;
    logic [1:0]           lvl_reg, lvl_next;
    logic [1:0]           need_reg, need_next;
    logic [UW-1:0]        used_reg, used_next;
    logic [POOL_PAGES-1:0] alloc_reg, alloc_next;
    logic [EW-1:0]        link_reg, link_next;
    pgmap_pkg::out_item_t res_reg, res_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [MW-1:0]        ram_wdata;
    logic [MW-1:0]        ram_rdata;

    logic [1:0]           lvl_inc;
    logic [PW-1:0]        new_page;
    logic                 rd_tag_ok;
    logic [EW-1:0]        rd_entry;
    logic [FW-1:0]        rd_frame;
    logic [FW-1:0]        rd_diff;
    logic                 rd_outside;
    logic [UW:0]          used_after;

    // Each entry carries a tag bit. A page taken from the pool flips its
    // flag, so every entry written before that reads as zero, as if the
    // page had been cleared. Each page is taken at most once after reset.
    pgmap_ram #(
        .WIDTH (MW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign lvl_inc    = lvl_reg + 2'd1;
    assign new_page   = used_reg[PW-1:0];
    assign rd_tag_ok  = ram_rdata[EW] == alloc_reg[page_reg[lvl_reg]];
    assign rd_entry   = rd_tag_ok ? ram_rdata[EW-1:0] : '0;
    assign rd_frame   = rd_entry[EW-1:PS];
    assign rd_diff    = rd_frame - pool_base;
    assign rd_outside = (rd_frame < pool_base) || (rd_diff >= POOL_LIMIT);
    assign used_after = {1'b0, used_reg} + (UW + 1)'(need_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = {page_reg[lvl_reg], idx_reg[lvl_reg]};
        ram_wdata = {alloc_reg[page_reg[lvl_reg]], link_reg};
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_addr_reg;
                ram_wdata = '0;
            end
            S_LINK:
            begin
                ram_we = 1'b1;
            end
            S_LEAF:
            begin
                ram_we    = 1'b1;
                ram_addr  = {page_reg[NL-1], idx_reg[NL-1]};
                ram_wdata = {alloc_reg[page_reg[NL-1]], pgmap_pkg::make_entry(frame_reg)};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        idx_next      = idx_reg;
        page_next     = page_reg;
        frame_next    = frame_reg;
        lvl_next      = lvl_reg;
        need_next     = need_reg;
        used_next     = used_reg;
        alloc_next    = alloc_reg;
        link_next     = link_reg;
        res_next      = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    for (int i = 0; i < NL; i++)
                    begin
                        idx_next[i] = in_data.virtual_address[PS + IW * (NL - 1 - i) +: IW];
                    end
                    page_next[0] = '0;
                    frame_next   = in_data.physical_frame;
                    lvl_next     = 2'd0;
                    need_next    = 2'd0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (!rd_entry[pgmap_pkg::ENT_PRESENT])
                begin
                    need_next  = 2'd3 - lvl_reg;
                    state_next = S_CHECK;
                end
                else if (rd_outside)
                begin
                    res_next.status       = pgmap_pkg::ST_OUTSIDE;
                    res_next.tables_taken = '0;
                    res_next.leaf_entry   = '0;
                    state_next            = S_DONE;
                end
                else
                begin
                    page_next[lvl_inc] = rd_diff[PW-1:0];
                    if (lvl_reg == 2'd2)
                    begin
                        need_next  = 2'd0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        lvl_next   = lvl_inc;
                        state_next = S_READ;
                    end
                end
            end
            S_CHECK:
            begin
                // The level that was missing stays in lvl_reg for the link pass.
                if (used_after > POOL_CAP)
                begin
                    res_next.status       = pgmap_pkg::ST_EXHAUSTED;
                    res_next.tables_taken = '0;
                    res_next.leaf_entry   = '0;
                    state_next            = S_DONE;
                end
                else if (need_reg == 2'd0)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC:
            begin
                alloc_next[new_page] = 1'b1;
                used_next            = used_reg + UW'(1);
                page_next[lvl_inc]   = new_page;
                link_next  = pgmap_pkg::make_entry(pool_base + FW'(new_page));
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (lvl_reg == 2'd2)
                begin
                    state_next = S_LEAF;
                end
                else
                begin
                    lvl_next   = lvl_inc;
                    state_next = S_ALLOC;
                end
            end
            S_LEAF:
            begin
                res_next.status       = pgmap_pkg::ST_MAPPED;
                res_next.tables_taken = need_reg;
                res_next.leaf_entry   = pgmap_pkg::make_entry(frame_reg);
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            used_reg     <= UW'(1);
            alloc_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            used_reg     <= used_next;
            alloc_reg    <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        page_reg  <= page_next;
        frame_reg <= frame_next;
        lvl_reg   <= lvl_next;
        need_reg  <= need_next;
        link_reg  <= link_next;
        res_reg   <= res_next;
    end

    assign in_stall  = state_reg != S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

### hw/rtl/four_level_page_map_engine_core.sv
`default_nettype none

// Four-level page map engine. Each input beat maps one 4 KiB page into a
// page table held in an internal single-port store of POOL_PAGES tables of
// 512 entries; pool page zero is the root table, and missing intermediate
// tables are taken from the pool in order and linked in as present, writable
// entries. A walk that meets an entry outside the pool, or that needs more
// tables than are left, maps nothing and reports that status instead. One
// mapping is in flight at a time: the input is stalled from the accept until
// the result beat moves to the output register. Each table level checked
// takes a store read, then an evaluate; then the pool is checked, each new
// table is taken and its link written, and the leaf is written, with every
// read and write on the one store port. After reset the store is swept once
// with the input stalled; configuration writes are taken throughout.
module four_level_page_map_engine_core #(
    parameter int POOL_PAGES = pgmap_pkg::POOL_PAGES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pgmap_pkg::FRAME_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pgmap_pkg::in_item_t           in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pgmap_pkg::out_item_t               out_data
);

    logic [pgmap_pkg::FRAME_W-1:0] pool_base_reg;
    logic [pgmap_pkg::FRAME_W-1:0] pool_base_next;
    logic                          res_valid;
    logic                          res_ready;
    pgmap_pkg::out_item_t          res_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        pool_base_next = pool_base_reg;
        if (cfg_valid && cfg_ready)
        begin
            pool_base_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else
        begin
            pool_base_reg <= pool_base_next;
        end
    end

    pgmap_walker #(
        .POOL_PAGES (POOL_PAGES)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_base (pool_base_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    pgmap_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;

    localparam int VA_W          = pgmap_pkg::VA_W;
    localparam int FRAME_W       = pgmap_pkg::FRAME_W;
    localparam int ENTRY_W       = pgmap_pkg::ENTRY_W;
    localparam int IDX_W         = pgmap_pkg::IDX_W;
    localparam int PAGE_SHIFT    = pgmap_pkg::PAGE_SHIFT;
    localparam int LEVELS        = pgmap_pkg::LEVELS;
    localparam int POOL_PAGES    = pgmap_pkg::POOL_PAGES_DEF;
    localparam int TABLE_ENTRIES = 1 << IDX_W;
    localparam int IDLE_LIMIT    = 40000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 215;
    localparam int LONG_HOLD     = 400;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

    // Mirrors the page-table store and the pool, and keeps the expected result
    // beats in the order in which their requests were accepted.
    class page_map_scoreboard;
        bit [ENTRY_W-1:0]     table_mem [POOL_PAGES*TABLE_ENTRIES];
        int unsigned          pages_in_use;
        bit [FRAME_W-1:0]     base_frame;
        pgmap_pkg::out_item_t expected_results [$];
        int                   mismatches;

        function new();
            foreach (table_mem[i])
                table_mem[i] = '0;
            pages_in_use = 1;
            base_frame   = '0;
            mismatches   = 0;
        endfunction

        function void set_pool_base(bit [FRAME_W-1:0] frame);
            base_frame = frame;
        endfunction

        function bit [ENTRY_W-1:0] link_entry(bit [FRAME_W-1:0] frame);
            return {frame, 10'd0, 2'b11};
        endfunction

        function void predict_mapping(pgmap_pkg::in_item_t req);
            pgmap_pkg::out_item_t want;
            bit [IDX_W-1:0]       idx [LEVELS];
            int unsigned          pg [LEVELS];
            int unsigned          first_missing;
            int unsigned          need;
            int unsigned          np;
            bit [ENTRY_W-1:0]     e;
            bit [FRAME_W-1:0]     f;
            bit [FRAME_W-1:0]     d;
            bit                   outside;
            want = '0;
            for (int l = 0; l < LEVELS; l++)
            begin
                idx[l] = req.virtual_address[PAGE_SHIFT + IDX_W*(LEVELS-1-l) +: IDX_W];
                pg[l]  = 0;
            end
            first_missing = LEVELS - 1;
            need          = 0;
            outside       = 1'b0;
            // Walk the present entries of the upper three levels; every check is
            // made before anything is written.
            for (int l = 0; l < LEVELS - 1; l++)
            begin
                if (!outside && need == 0)
                begin
                    e = table_mem[pg[l]*TABLE_ENTRIES + idx[l]];
                    if (e[pgmap_pkg::ENT_PRESENT])
                    begin
                        f = e[ENTRY_W-1:PAGE_SHIFT];
                        d = f - base_frame;
                        if (f < base_frame || d >= POOL_PAGES)
                            outside = 1'b1;
                        else
                            pg[l+1] = 32'(d);
                    end
                    else
                    begin
                        first_missing = l;
                        need          = LEVELS - 1 - l;
                    end
                end
            end
            if (outside)
                want.status = pgmap_pkg::ST_OUTSIDE;
            else if (need > POOL_PAGES - pages_in_use)
                want.status = pgmap_pkg::ST_EXHAUSTED;
            else
            begin
                for (int l = first_missing; l < LEVELS - 1; l++)
                begin
                    np = pages_in_use;
                    pages_in_use++;
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                        table_mem[np*TABLE_ENTRIES + k] = '0;
                    // The frame of a new table wraps at 40 bits.
                    f = base_frame + FRAME_W'(np);
                    table_mem[pg[l]*TABLE_ENTRIES + idx[l]] = link_entry(f);
                    pg[l+1] = np;
                end
                want.status       = pgmap_pkg::ST_MAPPED;
                want.tables_taken = need[1:0];
                want.leaf_entry   = link_entry(req.physical_frame);
                table_mem[pg[LEVELS-1]*TABLE_ENTRIES + idx[LEVELS-1]] = want.leaf_entry;
            end
            expected_results.push_back(want);
        endfunction

        function void check_result(pgmap_pkg::out_item_t got);
            pgmap_pkg::out_item_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d taken %0d leaf %h",
                             got.status, got.tables_taken, got.leaf_entry);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.tables_taken !== want.tables_taken ||
                got.leaf_entry !== want.leaf_entry)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected status %0d taken %0d leaf %h, %s",
                             want.status, want.tables_taken, want.leaf_entry,
                             $sformatf("got status %0d taken %0d leaf %h",
                                       got.status, got.tables_taken, got.leaf_entry));
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [FRAME_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    pgmap_pkg::in_item_t  in_data;
    logic             out_valid;
    logic             out_stall;
    pgmap_pkg::out_item_t out_data;

    page_map_scoreboard board = new();
    int sender_idle_pct;
    int receiver_idle_pct;
    int hold_requests;

    four_level_page_map_engine_core #(
        .POOL_PAGES(POOL_PAGES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always #10 clk = ~clk;

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic bit [VA_W-1:0] va_of(int unsigned i0, int unsigned i1, int unsigned i2,
                                            int unsigned i3, bit [PAGE_SHIFT-1:0] offs);
        return {i0[IDX_W-1:0], i1[IDX_W-1:0], i2[IDX_W-1:0], i3[IDX_W-1:0], offs};
    endfunction

    // Indices mostly come from a few values so that walks meet tables already linked.
    function automatic int unsigned pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 3);
        else if (r < 70)
            return TABLE_ENTRIES - 1;
        return $urandom_range(0, TABLE_ENTRIES - 1);
    endfunction

    task automatic send_map(input bit [VA_W-1:0] va, input bit [FRAME_W-1:0] frame);
        pgmap_pkg::in_item_t req;
        req.virtual_address = va;
        req.physical_frame  = frame;
        if (roll(sender_idle_pct))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (roll(sender_idle_pct))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.predict_mapping(req);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (board.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_pool_base(input bit [FRAME_W-1:0] frame);
        cfg_valid <= 1'b1;
        cfg_data  <= frame;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        board.set_pool_base(frame);
    endtask

    initial
    begin : receiver
        int unsigned hold_left;
        int          holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_result(out_data);
            if (hold_left == 0 && holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= roll(receiver_idle_pct);
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        bit [FRAME_W-1:0] seg_base [SEGMENTS];
        bit [FRAME_W-1:0] frame;
        int unsigned      r;
        sender_idle_pct   = 29;
        receiver_idle_pct = 63;
        hold_requests     = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Highest base: frames of new tables wrap and then lie below the base.
        write_pool_base(FRAME_MAX);
        send_map('0, '0);
        send_map('0, FRAME_MAX);
        send_map('1, FRAME_MAX);
        wait_all_results();

        // Base zero: the wrapped links now point at the root and its first tables,
        // so walks run through pages reached at more than one level.
        write_pool_base('0);
        send_map('0, 40'd1000);
        send_map('0, 40'd5);
        send_map(va_of(1, 0, 0, 0, 12'h000), '0);
        send_map(va_of(1, 2, 0, 0, 12'h123), 40'hAB);
        send_map(va_of(1, 2, 3, 4, 12'h800), 40'h80_0000_0000);
        send_map(va_of(1, 2, 3, 5, 12'h001), 40'hAA_AAAA_AAAA);
        send_map(48'hAAAA_AAAA_AAAA, 40'h55_5555_5555);
        // The pool is full from here on.
        send_map(48'h5555_5555_5555, 40'hAA_AAAA_AAAA);
        send_map(va_of(1, 3, 0, 0, 12'h000), 40'd7);
        send_map(va_of(1, 2, 6, 0, 12'h000), 40'd8);
        send_map(va_of(1, 2, 3, 6, 12'hFFF), 40'd9);
        wait_all_results();

        write_pool_base(40'd5);
        send_map(va_of(1, 2, 3, 4, 12'h000), 40'd6);
        send_map(48'hAAAA_AAAA_AAAA, 40'd12);
        send_map(va_of(511, 511, 511, 511, 12'h7FF), 40'd3);

        seg_base[0] = '0;
        seg_base[1] = 40'd1;
        seg_base[2] = FRAME_MAX;
        seg_base[3] = 40'd4;
        seg_base[4] = FRAME_W'({$urandom, $urandom});
        seg_base[5] = 40'd2;
        for (int s = 0; s < SEGMENTS; s++)
        begin
            wait_all_results();
            if (s == 2)
            begin
                sender_idle_pct   = 63;
                receiver_idle_pct = 29;
            end
            else if (s == 4)
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_pool_base(seg_base[s]);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                // One long hold-off at the receiver while requests keep coming.
                if (s == 1 && n == 60)
                    hold_requests++;
                r = $urandom_range(0, 99);
                if (r < 50)
                    frame = seg_base[s] + FRAME_W'($urandom_range(0, 20));
                else if (r < 70)
                    frame = FRAME_W'($urandom_range(0, 20));
                else
                    frame = FRAME_W'({$urandom, $urandom});
                send_map(va_of(pick_index(), pick_index(), pick_index(), pick_index(),
                               12'($urandom)), frame);
            end
        end

        wait_all_results();
        repeat (40) @(posedge clk);
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/pgmap_pkg.sv
hw/rtl/pgmap_ram.sv
hw/rtl/pgmap_outbuf.sv
hw/rtl/pgmap_walker.sv
hw/rtl/four_level_page_map_engine_core.sv
bench/tb_top.sv
